/* hdl/fos_pkg.sv */
package fos_pkg;

    localparam int WORD_W             = 32;
    localparam int INDEX_W            = 5;
    localparam int CFG_LEN_W          = 6;
    localparam int MAX_NEEDLE_DEFAULT = 32;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    typedef enum logic [0:0] {
        REG_NEEDLE_LENGTH = 1'b0,
        REG_UNUSED        = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        MODE_LOAD     = 1'b0,
        MODE_HAYSTACK = 1'b1
    } mode_t;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] match_start;
    } outcome_t;

    typedef struct packed {
        logic step;
        logic clear;
    } cell_ctrl_t;

endpackage

/* hdl/fos_cell.sv */
module fos_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fos_pkg::cell_ctrl_t         ctrl,
    input  logic                        load_en,
    input  logic [fos_pkg::WORD_W-1:0]  word,
    input  logic                        active,
    input  logic                        prev_match,
    output logic                        match,
    output logic                        match_next
);
    import fos_pkg::*;

    logic [WORD_W-1:0] needle_reg;
    logic              match_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            needle_reg <= word;
        end
    end

    assign match_next = prev_match && active && (needle_reg == word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

/* hdl/fos_out_buf.sv */
module fos_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fos_pkg::outcome_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output fos_pkg::outcome_t out_data
);
    import fos_pkg::*;

    logic     main_valid_reg;
    logic     skid_valid_reg;
    outcome_t main_data_reg;
    outcome_t skid_data_reg;
    logic     pop;

    assign pop = main_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

/* hdl/first_occurrence_search_core.sv */
// Streaming first-occurrence search. Transactions with mode 0 load a needle word into
// the slot given by needle_index; transactions with mode 1 present haystack words. A row
// of MAX_NEEDLE cells holds the needle, one word per cell, and each cell passes its
// partial-match bit to its neighbor, so one haystack word is taken every cycle with no
// gaps while in_stall is low. The first full match yields found with the haystack index
// of its start; an empty needle yields found at index 0. A haystack ending in last_word
// without a match yields not-found on that word. Results are registered in a two-entry
// output buffer; input continues while one waits and stalls only when both are full.
module first_occurrence_search_core #(
    parameter int MAX_NEEDLE = fos_pkg::MAX_NEEDLE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fos_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fos_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fos_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [fos_pkg::INDEX_W-1:0]     needle_index,
    input  logic signed [fos_pkg::WORD_W-1:0] word,
    input  logic                            last_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [fos_pkg::WORD_W-1:0]      match_start
);
    import fos_pkg::*;

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

    logic [CFG_LEN_W-1:0] needle_length_reg;
    logic [LEN_W-1:0]     used_len;
    reg_index_t           reg_sel;

    logic [WORD_W-1:0]    count_reg;
    logic [WORD_W-1:0]    count_next;
    logic                 answered_reg;
    logic                 answered_next;

    logic                 in_acc;
    logic                 hay_acc;
    logic                 hit;
    logic                 len_zero;
    logic                 push;
    logic                 buf_full;
    outcome_t             push_data;
    outcome_t             out_data;
    cell_ctrl_t           ctrl;

    logic [MAX_NEEDLE:0]   chain;
    logic [MAX_NEEDLE-1:0] match_next;
    logic [MAX_NEEDLE-1:0] tail_hit;
    logic [WORD_W-1:0]     word_bits;

    assign word_bits = word;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_length_reg <= '0;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_NEEDLE_LENGTH))
        begin
            needle_length_reg <= pwdata[CFG_LEN_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NEEDLE_LENGTH: prdata = APB_DATA_W'(needle_length_reg);
            default:           prdata = '0;
        endcase
    end

    assign used_len = (32'(needle_length_reg) > 32'(MAX_NEEDLE)) ?
                      LEN_W'(MAX_NEEDLE) : LEN_W'(needle_length_reg);
    assign len_zero = (used_len == '0);

    assign in_stall = buf_full;
    assign in_acc   = in_valid && !in_stall;
    assign hay_acc  = in_acc && (mode_t'(mode) == MODE_HAYSTACK);

    assign ctrl.step  = hay_acc && !answered_reg && !len_zero;
    assign ctrl.clear = hay_acc && last_word;

    assign chain[0] = 1'b1;

    genvar k;
    generate
        for (k = 0; k < MAX_NEEDLE; k++)
        begin : g_cell
            logic load_en;
            logic active;

            assign load_en = in_acc && (mode_t'(mode) == MODE_LOAD) &&
                             (32'(needle_index) == 32'(k));
            assign active  = (32'(used_len) > 32'(k));

            fos_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .load_en    (load_en),
                .word       (word_bits),
                .active     (active),
                .prev_match (chain[k]),
                .match      (chain[k+1]),
                .match_next (match_next[k])
            );

            assign tail_hit[k] = match_next[k] && (32'(used_len) == 32'(k + 1));
        end
    endgenerate

    assign hit = |tail_hit;

    always_comb
    begin
        push                  = hay_acc && !answered_reg && (len_zero || hit || last_word);
        push_data.found       = len_zero || hit;
        push_data.match_start = '0;
        if (!len_zero && hit)
        begin
            push_data.match_start = count_reg - WORD_W'(used_len) + WORD_W'(1);
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        answered_next = answered_reg;
        if (hay_acc)
        begin
            if (last_word)
            begin
                count_next    = '0;
                answered_next = 1'b0;
            end
            else
            begin
                if (count_reg != '1)
                begin
                    count_next = count_reg + WORD_W'(1);
                end
                if (push)
                begin
                    answered_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            answered_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            answered_reg <= answered_next;
        end
    end

    fos_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign found       = out_data.found;
    assign match_start = out_data.match_start;

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stalled while no result is pending.");

    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (hay_acc && answered_reg) |-> !push)
        else $error("Second result produced within one search.");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '1) |=> ((count_reg == '1) || (count_reg == '0)))
        else $error("Haystack position wrapped instead of saturating.");

endmodule
